/* src/gbr_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and the kernel weight map of the 5x5 RGB blur.
// Used by every module of the block but gbr_ram; depends on nothing.
package gbr_pkg;

    localparam int LINE_W     = 1024;
    localparam int ADDR_W     = $clog2(LINE_W);
    localparam int LINES      = 4;
    localparam int KSIZE      = 5;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 12;
    localparam int IMG_W_W    = 11;
    localparam int WGT_W      = 16;
    localparam int WGROUPS    = 6;
    localparam int GSUM_W     = 11;
    localparam int PROD_W     = GSUM_W + WGT_W;
    localparam int ACC_W      = 29;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WIDTH    = 3'd0,
        CFG_HEIGHT   = 3'd1,
        CFG_W_CENTRE = 3'd2,
        CFG_W_D1     = 3'd3,
        CFG_W_D2     = 3'd4,
        CFG_W_D4     = 3'd5,
        CFG_W_D5     = 3'd6,
        CFG_W_D8     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [IMG_W_W-1:0]            width;
        logic [ROW_W-1:0]              height;
        logic [WGROUPS-1:0][WGT_W-1:0] weight;
    } cfg_t;

    typedef struct packed {
        logic [31:0]      pix;
        logic [COL_W-1:0] x;
        logic [ROW_W-1:0] y;
        logic             emit;
    } pix_item_t;

    // weight group of each window tap, by squared distance from the centre
    function automatic logic [2:0] wsel(input int r, input int c);
        int dr;
        int dc;
        int d;
        dr = (r > 2) ? r - 2 : 2 - r;
        dc = (c > 2) ? c - 2 : 2 - c;
        d  = dr * dr + dc * dc;
        unique case (d)
            0:       wsel = 3'd0;
            1:       wsel = 3'd1;
            2:       wsel = 3'd2;
            4:       wsel = 3'd3;
            5:       wsel = 3'd4;
            default: wsel = 3'd5;
        endcase
    endfunction

endpackage

/* src/gaussian_blur_5x5_rgb_top.sv */
`timescale 1ns / 1ps
// Tagged pixels pass the queue, s1, window and s2, s3 (sums), s4 (products), output reg.
// One pixel per cycle when not stalled; line-store RAM read and written once per pixel.
// Reset (aresetn, synchronous, active low) clears counters, queue, window and
// pipeline valids and loads the default image size and weights; line stores
// are not cleared and need no clearing pass.
// Depends on gbr_pkg, gbr_front, gbr_fifo, gbr_back, gbr_ram.
module gaussian_blur_5x5_rgb_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [31:0]                       s_tdata,  // in_red, in_green, in_blue, in_alpha
    input  logic                              s_tuser,  // start_of_frame
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [55:0]                       m_tdata   // out_red, out_green, out_blue,
                                                        // out_alpha, out_column, out_row
);

    gbr_pkg::cfg_t      cfg_reg;
    gbr_pkg::pix_item_t f_item;
    gbr_pkg::pix_item_t q_item;
    logic               q_full, q_empty, q_pop, accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.width  <= 11'd640;
            cfg_reg.height <= 12'd480;
            cfg_reg.weight <= {16'd945, 16'd1841, 16'd2299, 16'd3585, 16'd4477, 16'd5591};
        end else if (cfg_wr_en) begin
            unique case (gbr_pkg::cfg_idx_t'(cfg_wr_index))
                gbr_pkg::CFG_WIDTH:    cfg_reg.width  <= cfg_wr_data[gbr_pkg::IMG_W_W-1:0];
                gbr_pkg::CFG_HEIGHT:   cfg_reg.height <= cfg_wr_data[gbr_pkg::ROW_W-1:0];
                gbr_pkg::CFG_W_CENTRE: cfg_reg.weight[0] <= cfg_wr_data;
                gbr_pkg::CFG_W_D1:     cfg_reg.weight[1] <= cfg_wr_data;
                gbr_pkg::CFG_W_D2:     cfg_reg.weight[2] <= cfg_wr_data;
                gbr_pkg::CFG_W_D4:     cfg_reg.weight[3] <= cfg_wr_data;
                gbr_pkg::CFG_W_D5:     cfg_reg.weight[4] <= cfg_wr_data;
                gbr_pkg::CFG_W_D8:     cfg_reg.weight[5] <= cfg_wr_data;
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    gbr_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .accept  (accept),
        .pix     (s_tdata),
        .sof     (s_tuser),
        .item    (f_item)
    );

    gbr_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (accept),
        .wr_item (f_item),
        .full    (q_full),
        .pop     (q_pop),
        .empty   (q_empty),
        .rd_item (q_item)
    );

    gbr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_empty  (q_empty),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* src/gbr_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read (read-first).
// No dependencies.
module gbr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rd_data_reg;

endmodule

/* src/gbr_front.sv */
`timescale 1ns / 1ps
// Front end: tracks column and row of each accepted pixel and tags those that complete a 5x5 window.
// Depends on gbr_pkg.
module gbr_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gbr_pkg::cfg_t         cfg,
    input  logic                  accept,
    input  logic [31:0]           pix,
    input  logic                  sof,
    output gbr_pkg::pix_item_t    item
);

    logic [gbr_pkg::COL_W-1:0]   col_reg, col_next;
    logic [gbr_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [gbr_pkg::COL_W-1:0]   x;
    logic [gbr_pkg::ROW_W-1:0]   y;
    logic [gbr_pkg::IMG_W_W-1:0] width_eff;

    always_comb begin
        x = sof ? '0 : col_reg;
        y = sof ? '0 : row_reg;
        width_eff = (cfg.width > gbr_pkg::IMG_W_W'(gbr_pkg::LINE_W)) ?
                    gbr_pkg::IMG_W_W'(gbr_pkg::LINE_W) : cfg.width;
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if ({1'b0, x} + 11'd1 >= width_eff) begin
                col_next = '0;
                row_next = ({1'b0, y} + 13'd1 >= {1'b0, cfg.height}) ?
                           '0 : y + 12'd1;
            end else begin
                col_next = x + 10'd1;
                row_next = y;
            end
        end
        item.pix  = pix;
        item.x    = x;
        item.y    = y;
        item.emit = (x >= 10'd4) && (y >= 12'd4);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

/* src/gbr_fifo.sv */
`timescale 1ns / 1ps
// Short queue of tagged pixels between front end and filter back end.
// Depends on gbr_pkg.
module gbr_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  gbr_pkg::pix_item_t wr_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output gbr_pkg::pix_item_t rd_item
);

    gbr_pkg::pix_item_t              entry_reg [gbr_pkg::FIFO_DEPTH];
    logic [gbr_pkg::FIFO_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [gbr_pkg::FIFO_AW:0]       count_reg;
    logic                            do_push, do_pop;

    assign full    = (count_reg == (gbr_pkg::FIFO_AW+1)'(gbr_pkg::FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wr_item;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_pop)  rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_reg + (gbr_pkg::FIFO_AW+1)'(do_push)
                                   - (gbr_pkg::FIFO_AW+1)'(do_pop);
        end
    end

    a_count_ptrs: assert property (@(posedge aclk) disable iff (!aresetn)
        full || (count_reg[gbr_pkg::FIFO_AW-1:0] == wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");

    a_pop_only: assert property (@(posedge aclk) disable iff (!aresetn)
        do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count did not drop on pop");

endmodule

/* src/gbr_back.sv */
`timescale 1ns / 1ps
// Back end: line stores, 5x5 window, weighted sums and the output register.
// Depends on gbr_pkg and gbr_ram.
module gbr_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  gbr_pkg::cfg_t      cfg,
    input  logic               q_empty,
    input  gbr_pkg::pix_item_t q_item,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [55:0]        m_tdata
);

    localparam int LW = 32 * gbr_pkg::LINES;

    typedef struct packed {
        logic [7:0]                alpha;
        logic [gbr_pkg::COL_W-1:0] col;
        logic [gbr_pkg::ROW_W-1:0] row;
    } meta_t;

    logic                      adv;
    logic [LW-1:0]             ram_rd;
    logic [LW-1:0]             col_word;
    logic [LW-1:0]             new_word;

    logic                      s1_valid_reg;
    gbr_pkg::pix_item_t        s1_item_reg;
    logic                      fwd_hit_reg;
    logic [LW-1:0]             fwd_data_reg;

    logic [31:0]               win_reg [gbr_pkg::KSIZE][gbr_pkg::KSIZE];
    logic [31:0]               col_pix [gbr_pkg::KSIZE];

    logic                      s2_valid_reg;
    meta_t                     s2_meta_reg;
    logic                      s3_valid_reg;
    meta_t                     s3_meta_reg;
    logic [gbr_pkg::GSUM_W-1:0] gsum_reg [3][gbr_pkg::WGROUPS];
    logic [gbr_pkg::GSUM_W-1:0] gsum_next [3][gbr_pkg::WGROUPS];
    logic                      s4_valid_reg;
    meta_t                     s4_meta_reg;
    logic [gbr_pkg::PROD_W-1:0] prod_reg [3][gbr_pkg::WGROUPS];
    logic [gbr_pkg::ACC_W-1:0] acc [3];
    logic [7:0]                chan [3];

    logic                      m_valid_reg;
    logic [55:0]               m_data_reg;

    assign adv   = !m_valid_reg || m_tready;
    assign q_pop = adv && !q_empty;

    gbr_ram #(.WIDTH(LW), .DEPTH(gbr_pkg::LINE_W)) u_lines (
        .aclk  (aclk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_item_reg.x),
        .wdata (new_word),
        .re    (q_pop),
        .raddr (q_item.x),
        .rdata (ram_rd)
    );

    // lane k holds line y-4+k; drop the oldest, append the new pixel
    always_comb begin
        col_word = fwd_hit_reg ? fwd_data_reg : ram_rd;
        new_word = {s1_item_reg.pix, col_word[LW-1:32]};
        for (int r = 0; r < gbr_pkg::LINES; r++) begin
            col_pix[r] = col_word[32*r +: 32];
        end
        col_pix[gbr_pkg::KSIZE-1] = s1_item_reg.pix;
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            for (int g = 0; g < gbr_pkg::WGROUPS; g++) begin
                gsum_next[ch][g] = '0;
            end
            for (int r = 0; r < gbr_pkg::KSIZE; r++) begin
                for (int c = 0; c < gbr_pkg::KSIZE; c++) begin
                    gsum_next[ch][gbr_pkg::wsel(r, c)] =
                        gsum_next[ch][gbr_pkg::wsel(r, c)] +
                        gbr_pkg::GSUM_W'(win_reg[r][c][8*ch +: 8]);
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            acc[ch] = '0;
            for (int g = 0; g < gbr_pkg::WGROUPS; g++) begin
                acc[ch] = acc[ch] + gbr_pkg::ACC_W'(prod_reg[ch][g]);
            end
            chan[ch] = (acc[ch][gbr_pkg::ACC_W-1:24] != '0) ? 8'hFF : acc[ch][23:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_item_reg  <= q_item;
            fwd_data_reg <= new_word;
            s2_meta_reg.alpha <= win_reg[2][3][31:24];
            s2_meta_reg.col   <= s1_item_reg.x - 10'd2;
            s2_meta_reg.row   <= s1_item_reg.y - 12'd2;
            s3_meta_reg  <= s2_meta_reg;
            gsum_reg     <= gsum_next;
            s4_meta_reg  <= s3_meta_reg;
            for (int ch = 0; ch < 3; ch++) begin
                for (int g = 0; g < gbr_pkg::WGROUPS; g++) begin
                    prod_reg[ch][g] <= gsum_reg[ch][g] * cfg.weight[g];
                end
            end
            m_data_reg <= {2'b00, s4_meta_reg.row, s4_meta_reg.col, s4_meta_reg.alpha,
                           chan[2], chan[1], chan[0]};
        end
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int r = 0; r < gbr_pkg::KSIZE; r++) begin
                for (int c = 0; c < gbr_pkg::KSIZE; c++) begin
                    win_reg[r][c] <= '0;
                end
            end
        end else if (adv) begin
            s1_valid_reg <= q_pop;
            // forward the word written this edge to a read of the same column
            fwd_hit_reg  <= q_pop && s1_valid_reg && (q_item.x == s1_item_reg.x);
            s2_valid_reg <= s1_valid_reg && s1_item_reg.emit;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            m_valid_reg  <= s4_valid_reg;
            if (s1_valid_reg) begin
                for (int r = 0; r < gbr_pkg::KSIZE; r++) begin
                    for (int c = 0; c < gbr_pkg::KSIZE - 1; c++) begin
                        win_reg[r][c] <= win_reg[r][c+1];
                    end
                    win_reg[r][gbr_pkg::KSIZE-1] <= col_pix[r];
                end
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(s1_valid_reg) && $stable(s4_valid_reg))
        else $error("pipeline moved during output stall");

    a_interior: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_meta_reg.col >= 10'd2) && (s3_meta_reg.row >= 12'd2))
        else $error("border pixel reached the filter");

endmodule

/* bench/gbr_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the 5x5 RGB blur: mirrors config writes and accepted pixels,
// predicts each blurred beat and compares it with the result channel. Uses gbr_pkg.
module gbr_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [gbr_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [gbr_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [31:0]                    s_tdata,
    input  logic                           s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [55:0]                    m_tdata,
    output int                             errors,
    output int                             pending
);

    typedef struct {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [9:0]  column;
        logic [11:0] row;
    } blur_pix_t;

    // weight register group of each tap, by squared distance from the centre
    localparam int unsigned TAP_GROUP [5][5] = '{
        '{5, 4, 3, 4, 5},
        '{4, 2, 1, 2, 4},
        '{3, 1, 0, 1, 3},
        '{4, 2, 1, 2, 4},
        '{5, 4, 3, 4, 5}
    };

    logic [10:0] img_width;
    logic [11:0] img_height;
    logic [15:0] kweight [6];
    logic [31:0] line_mem [4][1024];
    logic [31:0] win [5][5];
    int unsigned col_pos;
    int unsigned row_pos;
    blur_pix_t   blurred_q [$];

    task automatic report(input string what, input int got, input int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic logic [7:0] blur_channel(input int sh);
        longint unsigned acc;
        acc = 0;
        for (int r = 0; r < 5; r++)
            for (int c = 0; c < 5; c++)
                acc += longint'((win[r][c] >> sh) & 32'hff) * kweight[TAP_GROUP[r][c]];
        acc = acc >> 16;
        return (acc > 255) ? 8'd255 : acc[7:0];
    endfunction

    task automatic take_pixel(input logic [31:0] pix, input logic sof);
        logic [31:0] newcol [5];
        int unsigned lw;
        int unsigned x;
        int unsigned y;
        blur_pix_t   res;
        lw = (img_width > 1024) ? 1024 : img_width;
        if (sof) begin
            col_pos = 0;
            row_pos = 0;
        end
        x = col_pos;
        y = row_pos;
        for (int k = 0; k < 4; k++) newcol[k] = line_mem[k][x];
        for (int k = 0; k < 3; k++) line_mem[k][x] = line_mem[k+1][x];
        line_mem[3][x] = pix;
        newcol[4] = pix;
        for (int r = 0; r < 5; r++) begin
            for (int c = 0; c < 4; c++) win[r][c] = win[r][c+1];
            win[r][4] = newcol[r];
        end
        if (x >= 4 && y >= 4) begin
            res.red    = blur_channel(0);
            res.green  = blur_channel(8);
            res.blue   = blur_channel(16);
            res.alpha  = win[2][2][31:24];
            res.column = 10'(x - 2);
            res.row    = 12'(y - 2);
            blurred_q.push_back(res);
        end
        if (x + 1 >= lw) begin
            col_pos = 0;
            row_pos = (y + 1 >= img_height) ? 0 : ((y + 1) & 12'hfff);
        end else begin
            col_pos = x + 1;
        end
    endtask

    task automatic check_beat(input logic [55:0] d);
        blur_pix_t want;
        if (blurred_q.size() == 0) begin
            $display("unexpected result beat at %0t: %h", $realtime, d);
            errors++;
            return;
        end
        want = blurred_q.pop_front();
        if (d[7:0]   !== want.red)    report("red",    d[7:0],   want.red);
        if (d[15:8]  !== want.green)  report("green",  d[15:8],  want.green);
        if (d[23:16] !== want.blue)   report("blue",   d[23:16], want.blue);
        if (d[31:24] !== want.alpha)  report("alpha",  d[31:24], want.alpha);
        if (d[41:32] !== want.column) report("column", d[41:32], want.column);
        if (d[53:42] !== want.row)    report("row",    d[53:42], want.row);
    endtask

    initial begin
        errors  = 0;
        pending = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            img_width  = 11'd640;
            img_height = 12'd480;
            kweight    = '{16'd5591, 16'd4477, 16'd3585, 16'd2299, 16'd1841, 16'd945};
            for (int r = 0; r < 5; r++)
                for (int c = 0; c < 5; c++) win[r][c] = '0;
            col_pos = 0;
            row_pos = 0;
            blurred_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (gbr_pkg::cfg_idx_t'(cfg_wr_index))
                    gbr_pkg::CFG_WIDTH:  img_width  = cfg_wr_data[10:0];
                    gbr_pkg::CFG_HEIGHT: img_height = cfg_wr_data[11:0];
                    default: kweight[cfg_wr_index - gbr_pkg::CFG_W_CENTRE] = cfg_wr_data;
                endcase
            end
            if (m_tvalid && m_tready) check_beat(m_tdata);
            if (s_tvalid && s_tready) take_pixel(s_tdata, s_tuser);
        end
        pending = blurred_q.size();
    end

endmodule

/* bench/gaussian_blur_5x5_rgb_top_tb.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the 5x5 RGB blur: directed frames, then random frames
// and weights. Depends on gbr_pkg, gaussian_blur_5x5_rgb_top and gbr_checker.
module gaussian_blur_5x5_rgb_top_tb;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_wr_index = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;   // in_red, in_green, in_blue, in_alpha
    logic        s_tuser = 1'b0; // start_of_frame
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // out_red, out_green, out_blue, out_alpha, out_column, out_row
    logic        pix_taken = 1'b0;
    int          errors;
    int          pending;
    int          cycle = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          random_pixels = 0;

    gaussian_blur_5x5_rgb_top dut (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata
    );

    gbr_checker blur_check (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_index, .cfg_wr_data,
        .s_tvalid, .s_tready, .s_tdata, .s_tuser,
        .m_tvalid, .m_tready, .m_tdata, .errors, .pending
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // quiet window: no idling on either side
    function automatic bit may_idle();
        return !(cycle >= 1000 && cycle < 2500) && $urandom_range(99) < 8;
    endfunction

    always @(posedge aclk) begin
        cycle <= cycle + 1;
        pix_taken <= s_tvalid && s_tready;
        if (cycle >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off, started while a frame is
    // being offered, to back the block up
    always @(negedge aclk) begin
        if (!hold_done && random_pixels >= 500 && s_tvalid) begin
            hold_done = 1'b1;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= !may_idle();
        end
    end

    task automatic send_pixel(input logic [31:0] pix, input logic sof);
        while (may_idle()) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= sof;
        do @(negedge aclk); while (!pix_taken);
    endtask

    task automatic write_reg(input gbr_pkg::cfg_idx_t idx, input logic [15:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // drain all expected beats, then let the pipeline settle before a write
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic set_weights(input logic [15:0] w0, w1, w2, w3, w4, w5);
        write_reg(gbr_pkg::CFG_W_CENTRE, w0);
        write_reg(gbr_pkg::CFG_W_D1, w1);
        write_reg(gbr_pkg::CFG_W_D2, w2);
        write_reg(gbr_pkg::CFG_W_D4, w3);
        write_reg(gbr_pkg::CFG_W_D5, w4);
        write_reg(gbr_pkg::CFG_W_D8, w5);
    endtask

    // kind 0: random, 1: all ones, 2: checker of zeros and ones
    task automatic send_frame(input int w, input int h, input bit mark, input int kind,
                              input bit noise);
        logic [31:0] pix;
        for (int y = 0; y < h; y++) begin
            for (int x = 0; x < w; x++) begin
                case (kind)
                    1:       pix = '1;
                    2:       pix = ((x + y) % 2) ? '1 : '0;
                    default: pix = $urandom;
                endcase
                send_pixel(pix, (mark && x == 0 && y == 0) ||
                                (noise && $urandom_range(399) == 0));
            end
        end
    endtask

    initial begin
        int w;
        int h;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: smallest image, default weights, wrap without the frame mark
        write_reg(gbr_pkg::CFG_WIDTH, 16'd5);
        write_reg(gbr_pkg::CFG_HEIGHT, 16'd5);
        send_frame(5, 5, 1'b1, 2, 1'b0);
        send_frame(5, 5, 1'b0, 0, 1'b0);
        drain();
        // full-scale weights saturate, zero weights blank the image
        set_weights('1, '1, '1, '1, '1, '1);
        send_frame(5, 5, 1'b1, 1, 1'b0);
        drain();
        set_weights('0, '0, '0, '0, '0, '0);
        send_frame(5, 5, 1'b1, 2, 1'b0);
        drain();

        while (random_pixels < 1700) begin
            w = $urandom_range(5, 16);
            h = $urandom_range(5, 12);
            write_reg(gbr_pkg::CFG_WIDTH, 16'(w));
            write_reg(gbr_pkg::CFG_HEIGHT, 16'(h));
            if ($urandom_range(3) == 0)
                set_weights($urandom_range(0, 1) ? '1 : '0, 16'($urandom), 16'($urandom),
                            16'($urandom), 16'($urandom), 16'($urandom));
            else
                set_weights(16'($urandom_range(8000)), 16'($urandom_range(6000)),
                            16'($urandom_range(5000)), 16'($urandom_range(3000)),
                            16'($urandom_range(2500)), 16'($urandom_range(1500)));
            repeat ($urandom_range(1, 3)) begin
                send_frame(w, h, 1'b1, 0, 1'b1);
                random_pixels += w * h;
            end
            drain();
        end

        drain();
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* gaussian_blur_5x5_rgb_top.f */
src/gbr_pkg.sv
src/gbr_ram.sv
src/gbr_front.sv
src/gbr_fifo.sv
src/gbr_back.sv
src/gaussian_blur_5x5_rgb_top.sv
bench/gbr_checker.sv
bench/gaussian_blur_5x5_rgb_top_tb.sv
